[rtl/clss_pkg.sv]
// Package for the colour line similarity scorer: payload structs, register
// layout and fixed field widths. No dependencies.
`timescale 1ns / 1ps

package clss_pkg;

   localparam int POS_W      = 12;
   localparam int CH_W       = 8;
   localparam int SCORE_W    = 18;
   localparam int COUNT_W    = 11;
   localparam int SUM_W      = 40;
   localparam int REF_W      = 16;
   localparam int BIAS_W     = 18;
   localparam int CENTER_W   = 12;
   localparam int HALF_W     = 10;
   localparam int EXTENT_W   = 13;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 18;

   localparam logic [CSR_IDX_W-1:0] REG_REF_BLUE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_REF_GREEN     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_REF_RED       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SCORE_BIAS    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_CENTER = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_HALF_SPAN     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_LINE_EXTENT   = 3'd6;

   localparam logic [EXTENT_W-1:0] EXTENT_RESET = 13'd640;
   localparam logic [COUNT_W-1:0]  COUNT_MAX    = 11'd2047;

   typedef struct packed {
      logic [POS_W-1:0] position;
      logic [CH_W-1:0]  blue;
      logic [CH_W-1:0]  green;
      logic [CH_W-1:0]  red;
      logic             last_pixel;
   } req_type;

   typedef struct packed {
      logic signed [SCORE_W-1:0] score;
      logic [COUNT_W-1:0]        pixels_used;
   } rsp_type;

   typedef struct packed {
      logic signed [REF_W-1:0]  ref_blue;
      logic signed [REF_W-1:0]  ref_green;
      logic signed [REF_W-1:0]  ref_red;
      logic signed [BIAS_W-1:0] score_bias;
      logic [CENTER_W-1:0]      window_center;
      logic [HALF_W-1:0]        half_span;
      logic [EXTENT_W-1:0]      line_extent;
   } cfg_type;

   // One queued pixel: whether it lies in the window and whether it ends the line.
   typedef struct packed {
      logic            hit;
      logic            last;
      logic [CH_W-1:0] blue;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] red;
   } entry_type;

endpackage

[rtl/color_line_similarity_score.sv]
// Colour line similarity scorer. Pixels of one line arrive on the req_
// channel with their position; the pixel flagged last_pixel produces one
// response on rsp_ with the mean score and pixel count. The user must write
// registers via csr_ only while no line is in flight; this is not enforced.
//
// A front end takes one pixel per cycle while the queue has room, drops
// pixels outside the clipped window unless they end the line and queues
// the rest for the scoring engine. Each queued pixel in the window goes
// through the bit-serial square root and three divisions on the single
// shared divider, whose width NW is 40 at the default FRACTION_BITS of 14.
// The last pixel of a line also starts the final mean on that divider
// before the result appears. Pixels outside the window that do not end
// the line are dropped at one per cycle while the queue has room.
// Synchronous reset clears the running sum and count, empties the queue and
// loads the register defaults (line extent 640). A stalled receiver holds
// the result in the output register; the engine keeps working until it has
// a second result to hand over, and the queue then back-pressures req_.
// Depends on clss_pkg, clss_csr, clss_front, clss_queue and clss_back.
`timescale 1ns / 1ps

module color_line_similarity_score #(
   parameter int FRACTION_BITS = 14,
   parameter int QUEUE_DEPTH   = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  clss_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output clss_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [clss_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [clss_pkg::CSR_DATA_W-1:0]  csr_data
);
   import clss_pkg::*;

   cfg_type   cfg;
   entry_type push_data, head;
   logic      push, queue_full, pop, not_empty;

   clss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   clss_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .cfg        (cfg),
      .push       (push),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   clss_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head)
   );

   clss_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .not_empty (not_empty),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[rtl/clss_csr.sv]
// Configuration registers of the colour line similarity scorer.
// Depends on clss_pkg.
`timescale 1ns / 1ps

module clss_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [clss_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [clss_pkg::CSR_DATA_W-1:0]  csr_data,
   output clss_pkg::cfg_type                cfg
);
   import clss_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_REF_BLUE:      cfg_in.ref_blue      = csr_data[REF_W-1:0];
            REG_REF_GREEN:     cfg_in.ref_green     = csr_data[REF_W-1:0];
            REG_REF_RED:       cfg_in.ref_red       = csr_data[REF_W-1:0];
            REG_SCORE_BIAS:    cfg_in.score_bias    = csr_data[BIAS_W-1:0];
            REG_WINDOW_CENTER: cfg_in.window_center = csr_data[CENTER_W-1:0];
            REG_HALF_SPAN:     cfg_in.half_span     = csr_data[HALF_W-1:0];
            REG_LINE_EXTENT:   cfg_in.line_extent   = csr_data[EXTENT_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff             <= '0;
         cfg_ff.line_extent <= EXTENT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/clss_front.sv]
// Front end: accepts pixels, tests them against the clipped window and
// forwards only those that count or end the line. Depends on clss_pkg.
`timescale 1ns / 1ps

module clss_front (
   input  logic                 req_valid,
   output logic                 req_ready,
   input  clss_pkg::req_type    req_data,
   input  clss_pkg::cfg_type    cfg,
   output logic                 push,
   output clss_pkg::entry_type  push_data,
   input  logic                 queue_full
);
   import clss_pkg::*;

   localparam int WW = EXTENT_W + 2;

   logic signed [WW-1:0] start_raw, start_w, end_raw, end_low, end_w, ext_m1, pos_s;
   logic                 hit;

   always_comb begin
      ext_m1    = $signed({2'b00, cfg.line_extent}) - WW'(1);
      start_raw = $signed({3'b000, cfg.window_center}) - $signed({5'b00000, cfg.half_span});
      end_raw   = $signed({3'b000, cfg.window_center}) + $signed({5'b00000, cfg.half_span});
      start_w   = start_raw;
      if (start_w < 0) start_w = '0;
      if (start_w > $signed({2'b00, cfg.line_extent})) start_w = ext_m1;
      end_low   = (end_raw < start_w) ? start_w : end_raw;
      end_w     = (end_low > ext_m1) ? ext_m1 : end_low;
      pos_s     = $signed({{(WW-POS_W){1'b0}}, req_data.position});
      hit       = (pos_s >= start_w) && (pos_s < end_w);
   end

   // Pixels outside the window that do not end the line are simply dropped.
   assign req_ready       = !queue_full;
   assign push            = req_valid && !queue_full && (hit || req_data.last_pixel);
   assign push_data.hit   = hit;
   assign push_data.last  = req_data.last_pixel;
   assign push_data.blue  = req_data.blue;
   assign push_data.green = req_data.green;
   assign push_data.red   = req_data.red;

endmodule

[rtl/clss_queue.sv]
// Short register queue between the front end and the scoring engine.
// Depends on clss_pkg.
`timescale 1ns / 1ps

module clss_queue #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  clss_pkg::entry_type  push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output clss_pkg::entry_type  head
);
   import clss_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   entry_type        mem_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;

   assign full      = (cnt_ff == CW'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head      = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      if (pop)  rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      if (push && !pop) cnt_in = cnt_ff + CW'(1);
      if (pop && !push) cnt_in = cnt_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

[rtl/clss_div.sv]
// Restoring divider, one quotient bit per cycle, shared by the per-channel
// scaling and the final mean. No dependencies.
`timescale 1ns / 1ps

module clss_div #(
   parameter int NW = 40,
   parameter int DW = 24
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          done,
   output logic [NW-1:0] quo
);
   localparam int CW = $clog2(NW);

   logic [NW-1:0] quo_ff, quo_in;
   logic [DW-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [DW:0]   rem_sh;
   logic          fits;

   assign done = done_ff;
   assign quo  = quo_ff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff, quo_ff[NW-1]};
      fits    = (rem_sh >= {1'b0, den_ff});
      if (start) begin
         quo_in  = num;
         den_in  = den;
         rem_in  = '0;
         cnt_in  = CW'(NW - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? DW'(rem_sh - {1'b0, den_ff}) : rem_sh[DW-1:0];
         quo_in = {quo_ff[NW-2:0], fits};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule

[rtl/clss_back.sv]
// Scoring engine: square root, per-channel scaling, dot product, running
// sum and the final mean. Depends on clss_pkg and clss_div.
`timescale 1ns / 1ps

module clss_back #(
   parameter int FRACTION_BITS = 14
) (
   input  logic                 clock,
   input  logic                 reset,
   input  clss_pkg::cfg_type    cfg,
   input  logic                 not_empty,
   input  clss_pkg::entry_type  head,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output clss_pkg::rsp_type    rsp_data
);
   import clss_pkg::*;

   localparam int F    = FRACTION_BITS;
   localparam int SW   = 2 * CH_W + 2 + 2 * F;
   localparam int RTW  = SW / 2;
   localparam int DW   = RTW + 1;
   localparam int CNW  = 2 * F + CH_W + 1;
   localparam int NW   = (CNW > SUM_W) ? CNW : SUM_W;
   localparam int SCW  = $clog2(RTW);
   localparam int PRW  = F + 1 + REF_W;
   localparam int AW   = PRW + 2;
   localparam int DOTW = AW - F;
   localparam int PIXW = DOTW + 1;

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_ROOT = 9'b000000010,
      ST_NUM  = 9'b000000100,
      ST_DIVC = 9'b000001000,
      ST_MUL  = 9'b000010000,
      ST_ACC  = 9'b000100000,
      ST_FIN  = 9'b001000000,
      ST_DIVF = 9'b010000000,
      ST_EMIT = 9'b100000000
   } state_type;

   state_type            state_ff, state_in;
   logic [SW-1:0]        x_ff, x_in;
   logic [RTW-1:0]       root_ff, root_in;
   logic [RTW+1:0]       rem_ff, rem_in;
   logic [SCW-1:0]       step_ff, step_in;
   logic [DW-1:0]        den_ff, den_in;
   logic [1:0]           ch_ff, ch_in;
   logic [CH_W-1:0]      pix_ff [3];
   logic [CH_W-1:0]      pix_in [3];
   logic [F-1:0]         q_ff [3];
   logic [F-1:0]         q_in [3];
   logic signed [AW-1:0] acc_ff, acc_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 last_ff, last_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in, res_ff, res_in;

   logic [RTW+1:0]       root_sh, root_trial;
   logic                 root_fits;
   logic                 div_start, div_done;
   logic [NW-1:0]        div_num, div_quo;
   logic [DW-1:0]        div_den;
   logic [SW-1:0]        sq_sum;
   logic signed [REF_W-1:0] ref_sel;
   logic signed [PRW-1:0]   prod;
   logic signed [AW-1:0]    rnd;
   logic signed [PIXW-1:0]  pixel_value;
   logic [SUM_W:0]       sum_ext;
   logic [SUM_W-1:0]     mag;
   logic signed [SCORE_W-1:0] score_sat;

   clss_div #(.NW(NW), .DW(DW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      sq_sum = SW'(head.blue) * SW'(head.blue) + SW'(head.green) * SW'(head.green)
             + SW'(head.red) * SW'(head.red);
      sq_sum = sq_sum << (2 * F);

      root_sh    = {rem_ff[RTW-1:0], x_ff[SW-1:SW-2]};
      root_trial = {root_ff, 2'b01};
      root_fits  = (root_sh >= root_trial);

      unique case (ch_ff)
         2'd0:    ref_sel = cfg.ref_blue;
         2'd1:    ref_sel = cfg.ref_green;
         default: ref_sel = cfg.ref_red;
      endcase
      prod = $signed({1'b0, q_ff[ch_ff]}) * ref_sel;

      rnd         = acc_ff + AW'(1 << (F - 1));
      pixel_value = PIXW'(rnd >>> F) - PIXW'(cfg.score_bias);
      sum_ext     = {sum_ff[SUM_W-1], sum_ff} + (SUM_W + 1)'(pixel_value);

      mag = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : sum_ff;

      // The divisor is 2*half_span+1, so half_span is the rounding offset.
      if (state_ff == ST_FIN) begin
         div_num = NW'(mag) + NW'(cfg.half_span);
         div_den = DW'({cfg.half_span, 1'b1});
      end else begin
         div_num = NW'({pix_ff[ch_ff], {(2 * F){1'b0}}}) + NW'(den_ff >> 1);
         div_den = den_ff;
      end

      if (sum_ff[SUM_W-1]) begin
         score_sat = (div_quo > NW'(1 << (SCORE_W - 1))) ?
                     SCORE_W'(1 << (SCORE_W - 1)) : SCORE_W'(-div_quo);
      end else begin
         score_sat = (div_quo > NW'((1 << (SCORE_W - 1)) - 1)) ?
                     SCORE_W'((1 << (SCORE_W - 1)) - 1) : SCORE_W'(div_quo);
      end
   end

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      root_in      = root_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      den_in       = den_ff;
      ch_in        = ch_ff;
      pix_in       = pix_ff;
      q_in         = q_ff;
      acc_in       = acc_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pop          = 1'b0;
      div_start    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (not_empty) begin
               pop       = 1'b1;
               last_in   = head.last;
               pix_in[0] = head.blue;
               pix_in[1] = head.green;
               pix_in[2] = head.red;
               x_in      = sq_sum;
               root_in   = '0;
               rem_in    = '0;
               step_in   = SCW'(RTW - 1);
               state_in  = head.hit ? ST_ROOT : ST_FIN;
            end
         end
         ST_ROOT: begin
            rem_in  = root_fits ? (root_sh - root_trial) : root_sh;
            root_in = {root_ff[RTW-2:0], root_fits};
            x_in    = x_ff << 2;
            step_in = step_ff - SCW'(1);
            if (step_ff == '0) begin
               den_in   = DW'({root_ff[RTW-2:0], root_fits}) + DW'(1 << F);
               ch_in    = 2'd0;
               state_in = ST_NUM;
            end
         end
         ST_NUM: begin
            div_start = 1'b1;
            state_in  = ST_DIVC;
         end
         ST_DIVC: begin
            if (div_done) begin
               q_in[ch_ff] = div_quo[F-1:0];
               if (ch_ff == 2'd2) begin
                  ch_in    = 2'd0;
                  acc_in   = '0;
                  state_in = ST_MUL;
               end else begin
                  ch_in    = ch_ff + 2'd1;
                  state_in = ST_NUM;
               end
            end
         end
         ST_MUL: begin
            acc_in = acc_ff + AW'(prod);
            ch_in  = ch_ff + 2'd1;
            if (ch_ff == 2'd2) begin
               ch_in    = 2'd0;
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
               sum_in = sum_ext[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}}
                                       : {1'b0, {(SUM_W - 1){1'b1}}};
            end else begin
               sum_in = sum_ext[SUM_W-1:0];
            end
            if (count_ff != COUNT_MAX) count_in = count_ff + COUNT_W'(1);
            state_in = last_ff ? ST_FIN : ST_IDLE;
         end
         ST_FIN: begin
            div_start = 1'b1;
            state_in  = ST_DIVF;
         end
         ST_DIVF: begin
            if (div_done) begin
               res_in.score       = score_sat;
               res_in.pixels_used = count_ff;
               sum_in             = '0;
               count_in           = '0;
               state_in           = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      den_ff  <= den_in;
      ch_ff   <= ch_in;
      pix_ff  <= pix_in;
      q_ff    <= q_in;
      acc_ff  <= acc_in;
      last_ff <= last_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[tb/sv/tb_color_line_similarity_score.sv]
// Self-checking testbench for color_line_similarity_score: streams pixel lines
// through the block, predicts each line score and compares every response.
// Depends on clss_pkg and the color_line_similarity_score RTL.
`timescale 1ns / 1ps

module tb_color_line_similarity_score;
   import clss_pkg::*;

   localparam int FRAC         = 14;
   localparam int STALL_LIMIT  = 20000;
   localparam int HOLD_CYCLES  = 3000;
   localparam int SETTLE       = 300;
   localparam longint SUM_HI   = 64'sd549755813887;
   localparam longint SUM_LO   = -64'sd549755813888;
   localparam longint SCORE_HI = 131071;
   localparam longint SCORE_LO = -131072;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = REG_REF_BLUE;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   color_line_similarity_score u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   // Shadow of the block's registers and running state.
   longint ref_b, ref_g, ref_r, bias;
   int     center, half, extent;
   longint line_sum;
   int     line_count;

   req_type pending_pixels[$];
   rsp_type expected_scores[$];
   int      send_idle_pct = 11;
   int      recv_idle_pct = 57;
   int      errors = 0;
   int      lines_scored = 0;
   int      pixels_sent = 0;
   int      pixels_in_window = 0;
   bit      hold_done = 1'b0;
   int      hold_left = 0;
   int      quiet_cycles = 0;

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint pixel_similarity(longint unsigned b, longint unsigned g,
                                               longint unsigned r);
      longint unsigned den;
      longint qb, qg, qr, acc;
      den = int_sqrt((b * b + g * g + r * r) << (2 * FRAC)) + (64'd1 << FRAC);
      qb  = longint'(((b << (2 * FRAC)) + den / 2) / den);
      qg  = longint'(((g << (2 * FRAC)) + den / 2) / den);
      qr  = longint'(((r << (2 * FRAC)) + den / 2) / den);
      acc = qb * ref_b + qg * ref_g + qr * ref_r;
      return ((acc + (64'sd1 << (FRAC - 1))) >>> FRAC) - bias;
   endfunction

   // Scores one accepted pixel and queues the line result on the last one.
   function automatic void score_pixel(req_type px);
      int lo, hi;
      longint s, d, q;
      longint unsigned mag;
      rsp_type res;
      lo = center - half;
      hi = center + half;
      if (lo < 0) lo = 0;
      if (lo > extent) lo = extent - 1;
      if (hi < lo) hi = lo;
      if (hi > extent - 1) hi = extent - 1;
      if (int'(px.position) >= lo && int'(px.position) < hi) begin
         s = line_sum + pixel_similarity(px.blue, px.green, px.red);
         if (s > SUM_HI) s = SUM_HI;
         if (s < SUM_LO) s = SUM_LO;
         line_sum = s;
         if (line_count < 2047) line_count++;
         pixels_in_window++;
      end
      if (px.last_pixel) begin
         d   = 2 * half + 1;
         mag = (line_sum < 0) ? longint'(-line_sum) : line_sum;
         q   = longint'((mag + longint'(d) / 2) / longint'(d));
         if (line_sum < 0) q = -q;
         if (q > SCORE_HI) q = SCORE_HI;
         if (q < SCORE_LO) q = SCORE_LO;
         res.score       = q[SCORE_W-1:0];
         res.pixels_used = line_count[COUNT_W-1:0];
         expected_scores.push_back(res);
         line_sum   = 0;
         line_count = 0;
      end
   endfunction

   // Pixel driver: a new request is offered only once the current one is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            score_pixel(req_data);
            pixels_sent++;
         end
         if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= pending_pixels.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response monitor with random stalls and one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_scores.size() == 0) begin
               $display("%0t: unexpected response score=%0d count=%0d", $time,
                        rsp_data.score, rsp_data.pixels_used);
               errors++;
            end else begin
               if (rsp_data.score !== expected_scores[0].score) begin
                  $display("%0t: score expected %0d actual %0d", $time,
                           expected_scores[0].score, rsp_data.score);
                  errors++;
               end
               if (rsp_data.pixels_used !== expected_scores[0].pixels_used) begin
                  $display("%0t: pixels_used expected %0d actual %0d", $time,
                           expected_scores[0].pixels_used, rsp_data.pixels_used);
                  errors++;
               end
               void'(expected_scores.pop_front());
            end
            lines_scored++;
         end
         if (!hold_done && lines_scored == 40) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog on cycles without any accepted transfer.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, longint value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_REF_BLUE:      ref_b  = longint'($signed(value[REF_W-1:0]));
         REG_REF_GREEN:     ref_g  = longint'($signed(value[REF_W-1:0]));
         REG_REF_RED:       ref_r  = longint'($signed(value[REF_W-1:0]));
         REG_SCORE_BIAS:    bias   = longint'($signed(value[BIAS_W-1:0]));
         REG_WINDOW_CENTER: center = int'(value[CENTER_W-1:0]);
         REG_HALF_SPAN:     half   = int'(value[HALF_W-1:0]);
         REG_LINE_EXTENT:   extent = int'(value[EXTENT_W-1:0]);
         default: ;
      endcase
   endtask

   task automatic setup(longint rb, longint rg, longint rr, longint bs,
                        int c, int h, int e);
      write_reg(REG_REF_BLUE, rb);
      write_reg(REG_REF_GREEN, rg);
      write_reg(REG_REF_RED, rr);
      write_reg(REG_SCORE_BIAS, bs);
      write_reg(REG_WINDOW_CENTER, c);
      write_reg(REG_HALF_SPAN, h);
      write_reg(REG_LINE_EXTENT, e);
   endtask

   function automatic void add_pixel(int pos, int b, int g, int r, bit last);
      req_type px;
      px.position   = pos[POS_W-1:0];
      px.blue       = b[CH_W-1:0];
      px.green      = g[CH_W-1:0];
      px.red        = r[CH_W-1:0];
      px.last_pixel = last;
      pending_pixels.push_back(px);
   endfunction

   function automatic int channel();
      case ($urandom_range(9))
         0: return 0;
         1: return 255;
         default: return $urandom_range(255);
      endcase
   endfunction

   // A line of pixels mostly around the window, with some stray positions.
   function automatic int add_line();
      int n, lo, hi, pos;
      n  = $urandom_range(12, 1);
      lo = center - half - 3;
      hi = center + half + 3;
      if (lo < 0) lo = 0;
      if (hi > 4095) hi = 4095;
      for (int i = 0; i < n; i++) begin
         pos = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(hi, lo);
         add_pixel(pos, channel(), channel(), channel(), i == n - 1);
      end
      return n;
   endfunction

   task automatic drain();
      while (pending_pixels.size() != 0 || req_valid || expected_scores.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic longint pick(longint lo, longint hi);
      case ($urandom_range(5))
         0: return lo;
         1: return hi;
         default: return lo + longint'($urandom_range(32'(hi - lo)));
      endcase
   endfunction

   initial begin
      int budget, h, mode;
      ref_b = 0; ref_g = 0; ref_r = 0; bias = 0;
      center = 0; half = 0; extent = EXTENT_RESET;
      line_sum = 0; line_count = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed lines: window edges, black and white pixels, duplicates,
      // an empty line and a last pixel outside the window.
      setup(16384, -16384, 8000, 1000, 20, 5, 640);
      add_pixel(15, 0, 0, 0, 1'b0);
      add_pixel(24, 255, 255, 255, 1'b0);
      add_pixel(25, 255, 0, 0, 1'b0);
      add_pixel(14, 0, 255, 0, 1'b0);
      add_pixel(20, 0, 0, 255, 1'b0);
      add_pixel(20, 0, 0, 255, 1'b1);
      add_pixel(4095, 255, 255, 255, 1'b1);
      add_pixel(0, 0, 0, 0, 1'b0);
      add_pixel(18, 170, 85, 1, 1'b0);
      add_pixel(3000, 1, 2, 3, 1'b1);
      drain();
      setup(32767, 32767, 32767, -131072, 0, 0, 640);
      add_pixel(0, 255, 255, 255, 1'b1);
      drain();
      setup(-32768, -32768, -32768, 131071, 4095, 1023, 4096);
      add_pixel(3072, 255, 255, 255, 1'b0);
      add_pixel(4094, 200, 10, 77, 1'b0);
      add_pixel(4095, 9, 9, 9, 1'b1);
      drain();
      setup(12000, 3000, -5000, 0, 2, 3, 1);
      add_pixel(0, 100, 100, 100, 1'b1);
      drain();
      setup(12000, 3000, -5000, 0, 2, 3, 0);
      add_pixel(0, 100, 100, 100, 1'b0);
      add_pixel(1, 100, 100, 100, 1'b1);
      drain();

      // Random phases, each with fresh register values; every three phases share one idling mix.
      for (int phase = 0; phase < 9; phase++) begin
         mode = phase / 3;
         send_idle_pct = (mode == 0) ? 11 : (mode == 1) ? 57 : 0;
         recv_idle_pct = (mode == 0) ? 57 : (mode == 1) ? 11 : 0;
         h = ($urandom_range(7) == 0) ? int'(pick(0, 1023)) : $urandom_range(20);
         setup(pick(-32768, 32767), pick(-32768, 32767), pick(-32768, 32767),
               pick(-131072, 131071), int'(pick(0, 4095)), h,
               ($urandom_range(7) == 0) ? int'(pick(0, 8191)) : int'(pick(1, 4096)));
         budget = 220;
         while (budget > 0) budget -= add_line();
         drain();
      end

      $display("Scored %0d lines from %0d pixels, %0d of them inside the window.",
               lines_scored, pixels_sent, pixels_in_window);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[color_line_similarity_score.f]
rtl/clss_pkg.sv
rtl/clss_csr.sv
rtl/clss_front.sv
rtl/clss_queue.sv
rtl/clss_div.sv
rtl/clss_back.sv
rtl/color_line_similarity_score.sv
tb/sv/tb_color_line_similarity_score.sv
